// ===== src/atd_pkg.sv =====
// ----------------------------------------------------------------------------
// Tempo detector shared definitions
// Field widths, register indexes, status codes and the request and response
// bundles of the shared arithmetic units.
// ----------------------------------------------------------------------------
package atd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W    = 2;
  localparam int RATE_W    = 18;
  localparam int BPM_W     = 9;

  localparam int TEMPO_W   = 12;
  localparam int STATUS_W  = 3;
  localparam int LAG_OUT_W = 12;

  localparam int ENV_W     = 17;
  localparam int SM_W      = 26;
  localparam int SM_FRAC   = 8;
  localparam int SCORE_W   = 64;
  localparam int K_W       = 24;
  localparam int SQ_W      = 33;
  localparam int DIV_W     = 48;
  localparam int SQ_IN_W   = 34;
  localparam int SQ_OUT_W  = 17;

  localparam logic [TEMPO_W-1:0] TEMPO_SAT = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TEMPO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TEMPO = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SILENT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LAG_RANGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_PEAK   = 3'd4;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic [SQ_IN_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SQ_OUT_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== src/atd_in_if.sv =====
// ----------------------------------------------------------------------------
// Tempo detector sample channel
// Valid/ready channel carrying one audio sample pair and the end-of-clip flag.
// ----------------------------------------------------------------------------
interface atd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [atd_pkg::SAMPLE_W-1:0] sample_left;
  logic signed [atd_pkg::SAMPLE_W-1:0] sample_right;
  logic                                last;

  modport source (output valid, output sample_left, output sample_right, output last,
                  input ready);
  modport sink   (input valid, input sample_left, input sample_right, input last,
                  output ready);
endinterface

// ===== src/atd_out_if.sv =====
// ----------------------------------------------------------------------------
// Tempo detector result channel
// Valid/ready channel carrying one tempo estimate per clip.
// ----------------------------------------------------------------------------
interface atd_out_if;
  logic                           valid;
  logic                           ready;
  logic [atd_pkg::TEMPO_W-1:0]    tempo_tenths;
  logic [atd_pkg::STATUS_W-1:0]   status;
  logic [atd_pkg::LAG_OUT_W-1:0]  best_lag;

  modport source (output valid, output tempo_tenths, output status, output best_lag,
                  input ready);
  modport sink   (input valid, input tempo_tenths, input status, input best_lag,
                  output ready);
endinterface

// ===== src/autocorrelation_tempo_detector_core.sv =====
// ----------------------------------------------------------------------------
// Autocorrelation tempo detector
// Energy envelope of an audio clip, smoothed and autocorrelated to a tempo.
// ----------------------------------------------------------------------------
// Samples enter one beat per cycle while loading. Every HOP_SIZE samples
// (after the first half-block) the RMS of the last 2*HOP_SIZE samples goes
// to the envelope RAM; that frame takes the input away while the square-root
// unit runs. The beat flagged last starts the analysis, which owns the block
// until the result is handed over: two lag divisions, smoothing (one window
// update plus a division by the window size per frame), the mean division,
// rectification, and then for each lag L in the search range a pass of the
// correlation pipeline over N - L frame pairs, where N is the frame count,
// followed by the tempo conversion. Both RAMs are only read at entries
// written in the same clip, so there is no clearing pass. HOP_SIZE must be a
// power of two.
// ----------------------------------------------------------------------------
module autocorrelation_tempo_detector_core #(
  parameter int HOP_SIZE      = 512,
  parameter int SMOOTH_RADIUS = 5,
  parameter int MAX_FRAMES    = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  atd_in_if.sink                         in_if,
  atd_out_if.source                      out_if,
  input  logic                           cfg_we,
  input  logic [atd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [atd_pkg::CFG_W-1:0]      cfg_data
);

  localparam int HOP_W    = $clog2(HOP_SIZE);
  localparam int ENERGY_W = atd_pkg::SQ_W + HOP_W;
  localparam int FR_W     = $clog2(MAX_FRAMES + 1);
  localparam int ADDR_W   = $clog2(MAX_FRAMES);
  localparam int M_W      = $clog2(MAX_FRAMES + SMOOTH_RADIUS + 1);
  localparam int WIN_W    = $clog2(2 * SMOOTH_RADIUS + 2);
  localparam int ACC_W    = atd_pkg::ENV_W + WIN_W;
  localparam int TOT_W    = atd_pkg::SM_W + FR_W;
  localparam int DEN_W    = FR_W + HOP_W;
  localparam int PM_W     = atd_pkg::BPM_W + DEN_W;
  localparam int SW       = atd_pkg::SAMPLE_W;
  localparam int DW       = atd_pkg::DIV_W;

  // Controller state codes.
  localparam logic [4:0] S_LOAD     = 5'd0;
  localparam logic [4:0] S_FRAME    = 5'd1;
  localparam logic [4:0] S_SQRT     = 5'd2;
  localparam logic [4:0] S_CHECK    = 5'd3;
  localparam logic [4:0] S_DLO      = 5'd4;
  localparam logic [4:0] S_DHI      = 5'd5;
  localparam logic [4:0] S_SM_RD    = 5'd6;
  localparam logic [4:0] S_SM_ACC   = 5'd7;
  localparam logic [4:0] S_SM_DIV   = 5'd8;
  localparam logic [4:0] S_MEAN     = 5'd9;
  localparam logic [4:0] S_RECT_RD  = 5'd10;
  localparam logic [4:0] S_RECT_WR  = 5'd11;
  localparam logic [4:0] S_COR_INIT = 5'd12;
  localparam logic [4:0] S_COR      = 5'd13;
  localparam logic [4:0] S_CMP      = 5'd14;
  localparam logic [4:0] S_T_MUL    = 5'd15;
  localparam logic [4:0] S_T_DBL    = 5'd16;
  localparam logic [4:0] S_T_HLV    = 5'd17;
  localparam logic [4:0] S_T_DIV    = 5'd18;
  localparam logic [4:0] S_FINISH   = 5'd19;

  // Configuration registers.
  logic [atd_pkg::CHAN_W-1:0] chan_r;
  logic [atd_pkg::RATE_W-1:0] rate_r;
  logic [atd_pkg::BPM_W-1:0]  min_r;
  logic [atd_pkg::BPM_W-1:0]  max_r;

  // Clip state.
  logic [4:0]                  state_r;
  logic [ENERGY_W-1:0]         half_r;
  logic [ENERGY_W-1:0]         prev_r;
  logic [ENERGY_W-1:0]         hold_r;
  logic [HOP_W-1:0]            pos_r;
  logic [FR_W-1:0]             fc_r;
  logic                        have_prev_r;
  logic                        last_pend_r;
  logic [atd_pkg::ENV_W-1:0]   peak_r;

  // Analysis registers.
  logic [DW-1:0]               min_lag_r;
  logic [FR_W-1:0]             lag_lo_r;
  logic [FR_W-1:0]             lag_hi_r;
  logic [M_W-1:0]              m_r;
  logic [ACC_W-1:0]            win_r;
  logic [TOT_W-1:0]            tot_r;
  logic [atd_pkg::SM_W-1:0]    mean_r;
  logic [FR_W-1:0]             idx_r;
  logic [FR_W-1:0]             lag_r;
  logic                        issue_r;
  logic                        v1_r;
  logic                        v2_r;
  logic [2*atd_pkg::SM_W-1:0]  prod_r;
  logic [atd_pkg::SCORE_W-1:0] score_r;
  logic [atd_pkg::SCORE_W-1:0] best_r;
  logic [FR_W-1:0]             best_lag_r;
  logic [DW-1:0]               num_r;
  logic [DW-1:0]               den_r;
  logic [DW-1:0]               minden_r;
  logic [DW-1:0]               maxden_r;

  // Result staging and output register.
  logic [atd_pkg::TEMPO_W-1:0]   res_tempo_r;
  logic [atd_pkg::STATUS_W-1:0]  res_status_r;
  logic [atd_pkg::LAG_OUT_W-1:0] res_lag_r;
  logic                          out_valid_r;
  logic [atd_pkg::TEMPO_W-1:0]   out_tempo_r;
  logic [atd_pkg::STATUS_W-1:0]  out_status_r;
  logic [atd_pkg::LAG_OUT_W-1:0] out_lag_r;

  // Shared arithmetic units.
  atd_pkg::div_req_t  div_req;
  atd_pkg::div_rsp_t  div_rsp;
  atd_pkg::sqrt_req_t sqrt_req;
  atd_pkg::sqrt_rsp_t sqrt_rsp;

  // Memory ports.
  logic                       env_we;
  logic [ADDR_W-1:0]          env_waddr;
  logic [ADDR_W-1:0]          env_ra;
  logic [ADDR_W-1:0]          env_rb;
  logic [atd_pkg::ENV_W-1:0]  env_da;
  logic [atd_pkg::ENV_W-1:0]  env_db;
  logic                       sm_we;
  logic [ADDR_W-1:0]          sm_waddr;
  logic [atd_pkg::SM_W-1:0]   sm_wdata;
  logic [ADDR_W-1:0]          sm_rb;
  logic [atd_pkg::SM_W-1:0]   sm_da;
  logic [atd_pkg::SM_W-1:0]   sm_db;

  // Combinational helpers.
  logic                       in_acc;
  logic signed [SW:0]         mono;
  logic signed [2*SW+1:0]     mono_sq;
  logic [ENERGY_W-1:0]        half_nxt;
  logic [ENERGY_W:0]          frame_energy;
  logic [atd_pkg::K_W-1:0]    k_val;
  logic [DW-1:0]              dmax;
  logic [DW-1:0]              dmin;
  logic                       check_ok;
  logic                       range_bad;
  logic                       add_ok;
  logic                       sub_ok;
  logic [ACC_W-1:0]           win_nxt;
  logic [M_W-1:0]             win_hi;
  logic [M_W-1:0]             win_lo;
  logic [M_W-1:0]             m_last;
  logic [WIN_W-1:0]           win_cnt;
  logic [atd_pkg::SM_W-1:0]   div_sm;
  logic [TOT_W-1:0]           tot_nxt;
  logic [FR_W-1:0]            cor_end;
  logic                       better;
  logic [atd_pkg::SCORE_W-1:0] best_nxt;
  logic [DEN_W-1:0]           den_n;
  logic [PM_W-1:0]            minden_p;
  logic [PM_W-1:0]            maxden_p;
  logic                       num_low;
  logic                       num_high;

  assign in_acc   = in_if.valid && in_if.ready;
  assign mono     = (chan_r >= 2'd2)
                  ? ($signed({in_if.sample_left[SW-1], in_if.sample_left})
                     + $signed({in_if.sample_right[SW-1], in_if.sample_right}))
                  : $signed({in_if.sample_left[SW-1], in_if.sample_left});
  assign mono_sq  = mono * mono;
  assign half_nxt = half_r + ENERGY_W'(mono_sq[atd_pkg::SQ_W-1:0]);
  assign frame_energy = {1'b0, hold_r} + {1'b0, prev_r};

  // 60 * rate as two shifts.
  assign k_val = (atd_pkg::K_W'(rate_r) << 6) - (atd_pkg::K_W'(rate_r) << 2);
  assign dmax  = DW'(max_r) << HOP_W;
  assign dmin  = DW'(min_r) << HOP_W;

  assign check_ok  = (fc_r >= FR_W'(2)) && (peak_r != '0) && (min_r != '0) && (max_r != '0);
  assign range_bad = ((DW + 1)'(div_rsp.quotient) + 1'b1 >= (DW + 1)'(fc_r))
                  || (min_lag_r == '0);

  // Sliding window over the envelope: entry m enters, entry m-2R-1 leaves.
  assign add_ok  = (m_r < M_W'(fc_r));
  assign sub_ok  = (m_r >= M_W'(2 * SMOOTH_RADIUS + 1));
  assign win_nxt = win_r + (add_ok ? ACC_W'(env_da) : '0) - (sub_ok ? ACC_W'(env_db) : '0);
  assign win_hi  = add_ok ? m_r : M_W'(fc_r) - 1'b1;
  assign win_lo  = (m_r >= M_W'(2 * SMOOTH_RADIUS)) ? m_r - M_W'(2 * SMOOTH_RADIUS) : '0;
  assign win_cnt = WIN_W'(win_hi - win_lo + 1'b1);
  assign m_last  = M_W'(fc_r) - 1'b1 + M_W'(SMOOTH_RADIUS);
  assign div_sm  = div_rsp.quotient[atd_pkg::SM_W-1:0];
  assign tot_nxt = tot_r + TOT_W'(div_sm);

  assign cor_end  = fc_r - lag_r - 1'b1;
  assign better   = (score_r > best_r);
  assign best_nxt = better ? score_r : best_r;

  assign den_n    = {best_lag_r, {HOP_W{1'b0}}};
  assign minden_p = min_r * den_n;
  assign maxden_p = max_r * den_n;
  assign num_low  = (num_r < minden_r);
  assign num_high = (num_r > maxden_r);

  // Divider requests, one place per analysis step.
  always_comb begin
    div_req = '0;
    case (state_r)
      S_CHECK: begin
        div_req.start    = check_ok;
        div_req.dividend = DW'(k_val);
        div_req.divisor  = dmax;
      end
      S_DLO: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = DW'(k_val) + dmin - 1'b1;
        div_req.divisor  = dmin;
      end
      S_SM_ACC: begin
        div_req.start    = (m_r >= M_W'(SMOOTH_RADIUS));
        div_req.dividend = DW'(win_nxt) << atd_pkg::SM_FRAC;
        div_req.divisor  = DW'(win_cnt);
      end
      S_SM_DIV: begin
        div_req.start    = div_rsp.done && (m_r == m_last);
        div_req.dividend = DW'(tot_nxt);
        div_req.divisor  = DW'(fc_r);
      end
      S_T_HLV: begin
        div_req.start    = !num_high;
        div_req.dividend = (num_r << 4) + (num_r << 2) + den_r;
        div_req.divisor  = den_r << 1;
      end
      default: div_req = '0;
    endcase
  end

  assign sqrt_req.start    = (state_r == S_FRAME);
  assign sqrt_req.radicand = atd_pkg::SQ_IN_W'(frame_energy >> (HOP_W + 1));

  // Envelope RAM: written by the frame path, read by the smoothing window.
  assign env_we    = (state_r == S_SQRT) && sqrt_rsp.done;
  assign env_waddr = fc_r[ADDR_W-1:0];
  assign env_ra    = m_r[ADDR_W-1:0];
  assign env_rb    = ADDR_W'(m_r - M_W'(2 * SMOOTH_RADIUS + 1));

  // Smoothed RAM: smoothing and rectification write, rectification and
  // correlation read.
  always_comb begin
    sm_we    = 1'b0;
    sm_waddr = idx_r[ADDR_W-1:0];
    sm_wdata = (sm_da > mean_r) ? sm_da - mean_r : '0;
    if (state_r == S_SM_DIV) begin
      sm_we    = div_rsp.done;
      sm_waddr = ADDR_W'(m_r - M_W'(SMOOTH_RADIUS));
      sm_wdata = div_sm;
    end else if (state_r == S_RECT_WR) begin
      sm_we = 1'b1;
    end
  end
  assign sm_rb = ADDR_W'(idx_r + lag_r);

  atd_ram #(.WIDTH(atd_pkg::ENV_W), .DEPTH(MAX_FRAMES)) u_env_ram (
    .clk     (clk),
    .we      (env_we),
    .waddr   (env_waddr),
    .wdata   (sqrt_rsp.root),
    .raddr_a (env_ra),
    .rdata_a (env_da),
    .raddr_b (env_rb),
    .rdata_b (env_db)
  );

  atd_ram #(.WIDTH(atd_pkg::SM_W), .DEPTH(MAX_FRAMES)) u_sm_ram (
    .clk     (clk),
    .we      (sm_we),
    .waddr   (sm_waddr),
    .wdata   (sm_wdata),
    .raddr_a (idx_r[ADDR_W-1:0]),
    .rdata_a (sm_da),
    .raddr_b (sm_rb),
    .rdata_b (sm_db)
  );

  atd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  atd_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sqrt_req),
    .rsp   (sqrt_rsp)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r <= atd_pkg::CHAN_W'(2);
      rate_r <= atd_pkg::RATE_W'(44100);
      min_r  <= atd_pkg::BPM_W'(60);
      max_r  <= atd_pkg::BPM_W'(200);
    end else if (cfg_we) begin
      unique case (cfg_index)
        atd_pkg::CFG_CHANNELS:  chan_r <= cfg_data[atd_pkg::CHAN_W-1:0];
        atd_pkg::CFG_RATE:      rate_r <= cfg_data[atd_pkg::RATE_W-1:0];
        atd_pkg::CFG_MIN_TEMPO: min_r  <= cfg_data[atd_pkg::BPM_W-1:0];
        atd_pkg::CFG_MAX_TEMPO: max_r  <= cfg_data[atd_pkg::BPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Main controller. Loading, frame production and the whole analysis run
  // as one sequence; smoothing, rectification and correlation walk the RAMs one entry at a time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      half_r      <= '0;
      prev_r      <= '0;
      pos_r       <= '0;
      fc_r        <= '0;
      have_prev_r <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            last_pend_r <= in_if.last;
            if (pos_r == HOP_W'(HOP_SIZE - 1)) begin
              // A half-block closes; a frame needs the one before it.
              pos_r       <= '0;
              hold_r      <= prev_r;
              prev_r      <= half_nxt;
              half_r      <= '0;
              have_prev_r <= 1'b1;
              if (have_prev_r && (fc_r < FR_W'(MAX_FRAMES))) begin
                state_r <= S_FRAME;
              end else if (in_if.last) begin
                state_r <= S_CHECK;
              end
            end else begin
              pos_r  <= pos_r + 1'b1;
              half_r <= half_nxt;
              if (in_if.last) begin
                state_r <= S_CHECK;
              end
            end
          end
        end
        S_FRAME: begin
          state_r <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_rsp.done) begin
            fc_r <= fc_r + 1'b1;
            if (sqrt_rsp.root > peak_r) begin
              peak_r <= sqrt_rsp.root;
            end
            state_r <= last_pend_r ? S_CHECK : S_LOAD;
          end
        end
        S_CHECK: begin
          res_tempo_r <= '0;
          res_lag_r   <= '0;
          if (check_ok) begin
            state_r <= S_DLO;
          end else begin
            if (fc_r < FR_W'(2)) begin
              res_status_r <= atd_pkg::ST_SHORT;
            end else if (peak_r == '0) begin
              res_status_r <= atd_pkg::ST_SILENT;
            end else begin
              res_status_r <= atd_pkg::ST_LAG_RANGE;
            end
            state_r <= S_FINISH;
          end
        end
        S_DLO: begin
          if (div_rsp.done) begin
            min_lag_r <= div_rsp.quotient;
            state_r   <= S_DHI;
          end
        end
        S_DHI: begin
          if (div_rsp.done) begin
            if (range_bad) begin
              res_status_r <= atd_pkg::ST_LAG_RANGE;
              state_r      <= S_FINISH;
            end else if (min_lag_r > div_rsp.quotient) begin
              res_status_r <= atd_pkg::ST_NO_PEAK;
              state_r      <= S_FINISH;
            end else begin
              lag_lo_r <= min_lag_r[FR_W-1:0];
              lag_hi_r <= div_rsp.quotient[FR_W-1:0];
              m_r      <= '0;
              win_r    <= '0;
              tot_r    <= '0;
              state_r  <= S_SM_RD;
            end
          end
        end
        S_SM_RD: begin
          state_r <= S_SM_ACC;
        end
        S_SM_ACC: begin
          win_r <= win_nxt;
          if (m_r >= M_W'(SMOOTH_RADIUS)) begin
            state_r <= S_SM_DIV;
          end else begin
            m_r     <= m_r + 1'b1;
            state_r <= S_SM_RD;
          end
        end
        S_SM_DIV: begin
          if (div_rsp.done) begin
            tot_r <= tot_nxt;
            if (m_r == m_last) begin
              state_r <= S_MEAN;
            end else begin
              m_r     <= m_r + 1'b1;
              state_r <= S_SM_RD;
            end
          end
        end
        S_MEAN: begin
          if (div_rsp.done) begin
            mean_r  <= div_sm;
            idx_r   <= '0;
            state_r <= S_RECT_RD;
          end
        end
        S_RECT_RD: begin
          state_r <= S_RECT_WR;
        end
        S_RECT_WR: begin
          if (idx_r == fc_r - 1'b1) begin
            lag_r      <= lag_lo_r;
            best_r     <= '0;
            best_lag_r <= lag_lo_r;
            state_r    <= S_COR_INIT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RECT_RD;
          end
        end
        S_COR_INIT: begin
          idx_r   <= '0;
          score_r <= '0;
          issue_r <= 1'b1;
          v1_r    <= 1'b0;
          v2_r    <= 1'b0;
          state_r <= S_COR;
        end
        S_COR: begin
          // Read pair, product, accumulate: three stages in flight.
          if (issue_r) begin
            idx_r <= idx_r + 1'b1;
            if (idx_r == cor_end) begin
              issue_r <= 1'b0;
            end
          end
          v1_r   <= issue_r;
          prod_r <= sm_da * sm_db;
          v2_r   <= v1_r;
          if (v2_r) begin
            score_r <= score_r + atd_pkg::SCORE_W'(prod_r);
          end
          if (!issue_r && !v1_r && !v2_r) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          best_r <= best_nxt;
          if (better) begin
            best_lag_r <= lag_r;
          end
          if (lag_r == lag_hi_r) begin
            if (best_nxt == '0) begin
              res_status_r <= atd_pkg::ST_NO_PEAK;
              state_r      <= S_FINISH;
            end else begin
              state_r <= S_T_MUL;
            end
          end else begin
            lag_r   <= lag_r + 1'b1;
            state_r <= S_COR_INIT;
          end
        end
        S_T_MUL: begin
          num_r    <= DW'(k_val);
          den_r    <= DW'(den_n);
          minden_r <= DW'(minden_p);
          maxden_r <= DW'(maxden_p);
          state_r  <= S_T_DBL;
        end
        S_T_DBL: begin
          if (num_low) begin
            num_r <= num_r << 1;
          end else begin
            state_r <= S_T_HLV;
          end
        end
        S_T_HLV: begin
          if (num_high) begin
            den_r    <= den_r << 1;
            maxden_r <= maxden_r << 1;
          end else begin
            state_r <= S_T_DIV;
          end
        end
        S_T_DIV: begin
          if (div_rsp.done) begin
            res_tempo_r  <= (div_rsp.quotient > DW'(atd_pkg::TEMPO_SAT))
                          ? atd_pkg::TEMPO_SAT
                          : div_rsp.quotient[atd_pkg::TEMPO_W-1:0];
            res_lag_r    <= atd_pkg::LAG_OUT_W'(best_lag_r);
            res_status_r <= atd_pkg::ST_OK;
            state_r      <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hand the result over once the output register is free, then
          // start the next clip from a clean state.
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_tempo_r  <= res_tempo_r;
            out_status_r <= res_status_r;
            out_lag_r    <= res_lag_r;
            half_r       <= '0;
            prev_r       <= '0;
            pos_r        <= '0;
            fc_r         <= '0;
            have_prev_r  <= 1'b0;
            peak_r       <= '0;
            state_r      <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign in_if.ready         = (state_r == S_LOAD);
  assign out_if.valid        = out_valid_r;
  assign out_if.tempo_tenths = out_tempo_r;
  assign out_if.status       = out_status_r;
  assign out_if.best_lag     = out_lag_r;

  // The frame counter never passes the envelope capacity.
  assert property (@(posedge clk) disable iff (!rst_n) fc_r <= FR_W'(MAX_FRAMES))
    else $error("frame count beyond capacity");

  // A failed analysis reports zero tempo and zero lag.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != atd_pkg::ST_OK)) |->
    ((out_tempo_r == '0) && (out_lag_r == '0)))
    else $error("failure result carries a tempo or lag");

  // A good result always has a nonzero tempo.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == atd_pkg::ST_OK)) |-> (out_tempo_r != '0))
    else $error("good result with zero tempo");

  // The shared divider is never restarted while it is working.
  assert property (@(posedge clk) disable iff (!rst_n) div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // The square-root unit is started only from an idle unit.
  assert property (@(posedge clk) disable iff (!rst_n) sqrt_req.start |-> !sqrt_rsp.busy)
    else $error("square root started while busy");

endmodule

// ===== src/atd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module atd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_a_r <= mem_r[raddr_a];
    rd_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule

// ===== src/atd_div.sv =====
// ----------------------------------------------------------------------------
// Tempo detector divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module atd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  atd_pkg::div_req_t req,
  output atd_pkg::div_rsp_t rsp
);

  localparam int W     = atd_pkg::DIV_W;
  localparam int CNT_W = $clog2(W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [W-1:0]     dsr_r;
  logic [W:0]       rem_sh;
  logic             fits;

  assign rem_sh = {rem_r, quo_r[W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(W - 1);
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dsr_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= fits ? W'(rem_sh - {1'b0, dsr_r}) : rem_sh[W-1:0];
        quo_r <= {quo_r[W-2:0], fits};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== src/atd_sqrt.sv =====
// ----------------------------------------------------------------------------
// Tempo detector square root
// Digit-by-digit floor square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module atd_sqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  atd_pkg::sqrt_req_t req,
  output atd_pkg::sqrt_rsp_t rsp
);

  localparam int XW    = atd_pkg::SQ_IN_W;
  localparam int RW    = atd_pkg::SQ_OUT_W;
  localparam int REM_W = RW + 2;
  localparam int STEPS = XW / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [XW-1:0]    x_r;
  logic [REM_W-1:0] rem_r;
  logic [RW-1:0]    root_r;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  assign rem_sh = {rem_r, x_r[XW-1:XW-2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS - 1);
        x_r    <= req.radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_r <= {root_r[RW-2:0], fits};
        x_r    <= {x_r[XW-3:0], 2'b00};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule
